// ----- hw/rtl/b2d_pkg.sv -----
// ---------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants of the binary to decimal digit converter.
// ---------------------------------------------------------------------------
package b2d_pkg;

  localparam int DIG_W = 4;
  localparam int CHAR_W = 6;

  localparam logic [DIG_W-1:0]  DABBLE_THRESH = 4'd5;
  localparam logic [DIG_W-1:0]  DABBLE_ADD    = 4'd3;
  localparam logic [DIG_W-1:0]  DIGIT_MAX     = 4'd9;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Control word that every digit cell of the chain receives.
  typedef struct packed {
    logic clr;        // clear the digit ahead of a new conversion
    logic dabble;     // add-3 correction and one-bit shift towards the top
    logic shift_dig;  // pass whole digits one place towards the top
  } cell_ctl_t;

endpackage

// ----- hw/rtl/b2d_if.sv -----
// ---------------------------------------------------------------------------
// b2d_if
// Valid/ready channel interfaces: binary value in, decimal characters out.
// ---------------------------------------------------------------------------
interface b2d_in_if #(
  parameter int VALUE_BITS = 63
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2d_pkg::CHAR_W-1:0]  digit_char;
  logic                        last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- hw/rtl/b2d_cell.sv -----
// ---------------------------------------------------------------------------
// b2d_cell
// One BCD digit of the conversion chain: shift-add-3 step or digit shift.
// ---------------------------------------------------------------------------
module b2d_cell (
  input  logic                       clk,
  input  b2d_pkg::cell_ctl_t         ctl,
  input  logic                       bit_in,
  input  logic [b2d_pkg::DIG_W-1:0]  dig_in,
  output logic                       bit_out,
  output logic [b2d_pkg::DIG_W-1:0]  dig_out
);

  logic [b2d_pkg::DIG_W-1:0] dig_r;
  logic [b2d_pkg::DIG_W-1:0] dig_nxt;
  logic [b2d_pkg::DIG_W-1:0] adj;

  // A digit of five or more would exceed nine after doubling, so it is
  // corrected first; the carry then leaves through the top bit.
  always_comb begin
    if (dig_r >= b2d_pkg::DABBLE_THRESH) begin
      adj = dig_r + b2d_pkg::DABBLE_ADD;
    end else begin
      adj = dig_r;
    end
  end

  always_comb begin
    dig_nxt = dig_r;
    if (ctl.clr) begin
      dig_nxt = '0;
    end else if (ctl.dabble) begin
      dig_nxt = {adj[b2d_pkg::DIG_W-2:0], bit_in};
    end else if (ctl.shift_dig) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign bit_out = adj[b2d_pkg::DIG_W-1];
  assign dig_out = dig_r;

endmodule

// ----- hw/rtl/binary_to_decimal_digits.sv -----
// ---------------------------------------------------------------------------
// binary_to_decimal_digits
// Converts an unsigned binary value to a stream of ASCII decimal digits.
// ---------------------------------------------------------------------------
// Usage: one value is taken from in_ch per transfer. The block answers with
// one out_ch transfer per decimal digit, most significant first, as ASCII
// '0' to '9'; leading zeros are dropped, so zero gives a single '0'. The
// final digit of each value carries last.
// Timing: a value is shifted through a chain of BCD digit cells, one bit per
// cycle. The chain then moves its digits one place towards the output per
// cycle unless a digit is held up by a full output register: leading zeros are
// dropped on the way and every other digit is loaded into the output register.
// The chain has 19 digit cells at the default width of 63 bits.
// in_ch.ready is high only while no item is in hand. A new value may be taken
// while the final digit still waits in the output register.
// Stalls: while a digit waits in the output register with out_ch.ready low,
// the chain waits; leading zeros are still dropped. Reset (synchronous,
// active low) empties the output register and returns the block to idle.
// ---------------------------------------------------------------------------
module binary_to_decimal_digits #(
  parameter int VALUE_BITS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  b2d_in_if.sink      in_ch,
  b2d_out_if.source   out_ch
);

  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCNT_W = $clog2(VALUE_BITS + 1);
  localparam int DCNT_W = $clog2(NUM_DIGITS + 1);

  b2d_pkg::state_t state_r;
  b2d_pkg::state_t state_nxt;

  logic [VALUE_BITS-1:0]        val_r;
  logic [BCNT_W-1:0]            bit_cnt_r;
  logic [DCNT_W-1:0]            dig_cnt_r;
  logic                         started_r;
  logic                         out_valid_r;
  logic [b2d_pkg::CHAR_W-1:0]   out_dig_r;
  logic                         out_last_r;

  b2d_pkg::cell_ctl_t           ctl;
  logic [NUM_DIGITS-1:0]        bit_w;
  logic [b2d_pkg::DIG_W-1:0]    dig_w [NUM_DIGITS];
  logic [b2d_pkg::DIG_W-1:0]    din_w [NUM_DIGITS];
  logic [b2d_pkg::DIG_W-1:0]    top_dig;

  logic in_fire;
  logic out_free;
  logic is_last;
  logic skip;
  logic emit;

  // Digit chain: cell 0 is the least significant digit.
  assign bit_w[0] = val_r[VALUE_BITS-1];
  assign din_w[0] = '0;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i < NUM_DIGITS - 1) begin : g_mid
      b2d_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (bit_w[i]),
        .dig_in  (din_w[i]),
        .bit_out (bit_w[i+1]),
        .dig_out (dig_w[i])
      );
      assign din_w[i+1] = dig_w[i];
    end else begin : g_top
      b2d_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (bit_w[i]),
        .dig_in  (din_w[i]),
        .bit_out (),
        .dig_out (dig_w[i])
      );
    end
  end

  assign top_dig  = dig_w[NUM_DIGITS-1];
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = (dig_cnt_r == DCNT_W'(1));
  assign skip     = !started_r && (top_dig == '0) && !is_last;
  assign emit     = (state_r == b2d_pkg::ST_EMIT) && !skip && out_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b2d_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = b2d_pkg::ST_CONV;
        end
      end
      b2d_pkg::ST_CONV: begin
        if (bit_cnt_r == BCNT_W'(1)) begin
          state_nxt = b2d_pkg::ST_EMIT;
        end
      end
      b2d_pkg::ST_EMIT: begin
        if (emit && is_last) begin
          state_nxt = b2d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = b2d_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_ch.ready   = 1'b0;
    ctl.clr       = 1'b0;
    ctl.dabble    = 1'b0;
    ctl.shift_dig = 1'b0;
    case (state_r)
      b2d_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.clr     = in_ch.valid;
      end
      b2d_pkg::ST_CONV: begin
        ctl.dabble = 1'b1;
      end
      b2d_pkg::ST_EMIT: begin
        ctl.shift_dig = skip || emit;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2d_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;

      if (in_fire) begin
        bit_cnt_r <= BCNT_W'(VALUE_BITS);
      end else if (state_r == b2d_pkg::ST_CONV) begin
        bit_cnt_r <= bit_cnt_r - BCNT_W'(1);
      end

      if ((state_r == b2d_pkg::ST_CONV) && (bit_cnt_r == BCNT_W'(1))) begin
        dig_cnt_r <= DCNT_W'(NUM_DIGITS);
        started_r <= 1'b0;
      end else if (ctl.shift_dig) begin
        dig_cnt_r <= dig_cnt_r - DCNT_W'(1);
        if (emit) begin
          started_r <= 1'b1;
        end
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r <= in_ch.value;
    end else if (state_r == b2d_pkg::ST_CONV) begin
      val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
    end
    if (emit) begin
      out_dig_r  <= b2d_pkg::ASCII_ZERO + {2'b00, top_dig};
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_dig_r;
  assign out_ch.last       = out_last_r;

`ifndef SYNTH
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dig_r >= b2d_pkg::ASCII_ZERO) && (out_dig_r <= b2d_pkg::ASCII_NINE))
    else $error("emitted character is not a decimal digit");

  a_top_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == b2d_pkg::ST_EMIT) |-> (top_dig <= b2d_pkg::DIGIT_MAX))
    else $error("digit cell holds a value above nine");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == b2d_pkg::ST_CONV) |-> (bit_cnt_r != '0))
    else $error("bit counter ran out during conversion");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == b2d_pkg::ST_EMIT) |-> (dig_cnt_r != '0))
    else $error("digit counter ran out during emission");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (state_r == b2d_pkg::ST_IDLE) && out_valid_r && out_last_r)
    else $error("final digit did not end the item");
`endif

endmodule

// ----- tb/binary_to_decimal_digits_test.sv -----
// ---------------------------------------------------------------------------
// binary_to_decimal_digits_test
// Self-checking bench for the binary to decimal digit converter. Values are
// fed through the input channel and every digit transfer on the output
// channel is compared with a digit string worked out in the bench, with
// random idling on both sides, a long receiver hold-off and a full drain.
// ---------------------------------------------------------------------------
module binary_to_decimal_digits_test;

  localparam int VALUE_BITS  = 63;
  localparam int N_RANDOM    = 110;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 120;

  typedef struct packed {
    logic [b2d_pkg::CHAR_W-1:0] digit_char;
    logic                       last;
  } digit_t;

  typedef struct {
    logic [VALUE_BITS-1:0] number;
    int unsigned           idle_before;
    bit                    wait_for_drain;
  } number_item_t;

  logic clk;
  logic rst_n;

  b2d_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  b2d_out_if                           out_ch ();

  binary_to_decimal_digits #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  number_item_t queued_numbers [$];
  digit_t       expected_digits [$];
  int unsigned  numbers_total;
  int unsigned  numbers_taken;
  int unsigned  error_count;
  int unsigned  hold_left;
  bit           hold_done;
  int unsigned  sink_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("Some tests failed");
    $finish;
  end

  // Works out the decimal digits of one number, most significant first.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] number);
    logic [63:0] rest;
    logic [3:0]  decimal [$];
    digit_t      d;
    rest = 64'(number);
    do begin
      decimal.push_front(4'(rest % 64'd10));
      rest = rest / 64'd10;
    end while (rest != 64'd0);
    for (int k = 0; k < decimal.size(); k++) begin
      d.digit_char = b2d_pkg::ASCII_ZERO + {2'b00, decimal[k]};
      d.last       = (k == decimal.size() - 1);
      expected_digits.push_back(d);
    end
  endfunction

  function automatic void report_error(input string what, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
    if (error_count < 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, act_val);
    error_count++;
  endfunction

  function automatic int unsigned pick_idle();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task automatic queue_number(input logic [VALUE_BITS-1:0] number,
                              input int unsigned idle, input bit drain);
    number_item_t item;
    item.number         = number;
    item.idle_before    = idle;
    item.wait_for_drain = drain;
    queued_numbers.push_back(item);
  endtask

  // Sender: idle cycles before an item are only counted while the block would
  // take it, so that every gap really delays the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.value   <= '0;
      numbers_taken <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value);
        numbers_taken <= numbers_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_numbers.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (queued_numbers[0].idle_before != 0) begin
          if (in_ch.ready && !in_ch.valid) queued_numbers[0].idle_before--;
          in_ch.valid <= 1'b0;
        end else if (queued_numbers[0].wait_for_drain && expected_digits.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.value <= queued_numbers[0].number;
          void'(queued_numbers.pop_front());
        end
      end
    end
  end

  // One long receiver hold-off, so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && numbers_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks each digit transfer and decides the next ready.
  always @(posedge clk) begin
    digit_t want;
    bit     may_stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_idle    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digits.size() == 0) begin
          report_error("unexpected digit_char", 64'd0, 64'(out_ch.digit_char));
        end else begin
          want = expected_digits.pop_front();
          if (out_ch.digit_char !== want.digit_char)
            report_error("digit_char", 64'(want.digit_char), 64'(out_ch.digit_char));
          if (out_ch.last !== want.last)
            report_error("last", 64'(want.last), 64'(out_ch.last));
        end
      end
      may_stall = !(numbers_taken >= 40 && numbers_taken < 60) &&
                  (numbers_taken + 25 < numbers_total);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_idle != 0) begin
        sink_idle--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (may_stall && $urandom_range(0, 5) == 0) sink_idle = $urandom_range(1, 4);
      end
    end
  end

  initial begin
    logic [63:0]  raw;
    int unsigned  idle;
    int unsigned  waited;
    rst_n        = 1'b0;
    error_count  = 0;

    // Extremes of the field, digit-count boundaries and bit patterns.
    queue_number(63'd0, 0, 1'b0);
    queue_number(63'd1, pick_idle(), 1'b0);
    queue_number(63'd9, pick_idle(), 1'b0);
    queue_number(63'd10, pick_idle(), 1'b0);
    queue_number(63'd99, pick_idle(), 1'b0);
    queue_number(63'd100, pick_idle(), 1'b0);
    queue_number(63'd101, pick_idle(), 1'b0);
    queue_number(63'd1000000000, pick_idle(), 1'b0);
    queue_number(63'd999999999999999999, pick_idle(), 1'b0);
    queue_number(63'd1000000000000000000, pick_idle(), 1'b0);
    queue_number(63'h7FFF_FFFF_FFFF_FFFF, pick_idle(), 1'b0);
    queue_number(63'h7FFF_FFFF_FFFF_FFFE, pick_idle(), 1'b0);
    queue_number(63'h4000_0000_0000_0000, pick_idle(), 1'b0);
    queue_number(63'h5555_5555_5555_5555, pick_idle(), 1'b0);
    queue_number(63'h2AAA_AAAA_AAAA_AAAA, pick_idle(), 1'b0);
    queue_number(63'd1234567890123456789, pick_idle(), 1'b0);
    queue_number(63'd0, 0, 1'b0);
    queue_number(63'd0, 0, 1'b0);
    queue_number(63'd8, pick_idle(), 1'b0);
    queue_number(63'd90909090909090909, pick_idle(), 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       raw = 64'($urandom_range(0, 9));
        1:       raw = 64'($urandom_range(0, 1000));
        2:       raw = 64'h7FFF_FFFF_FFFF_FFFF;
        default: raw = raw >> $urandom_range(0, 62);
      endcase
      // Gap-free stretches around the hold-off and in the last part of the run.
      if ((i >= 45 && i < 75) || (i + 25 >= N_RANDOM))
        idle = 0;
      else
        idle = pick_idle();
      queue_number(raw[VALUE_BITS-1:0], idle, (i == 0) || (i == 100));
    end
    numbers_total = queued_numbers.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (numbers_taken == numbers_total);
    waited = 0;
    while (expected_digits.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_digits.size() != 0)
      report_error("digits never delivered", 64'(expected_digits.size()), 64'd0);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
